/* hw/rtl/mvt_pkg.sv */
package mvt_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned DataW           = 32;
  localparam int unsigned NumRows         = 4;
  localparam int unsigned NumCols         = 4;
  localparam int unsigned NumRegs         = 8;
  localparam int unsigned RegIdxW         = 4;
  localparam int unsigned CfgDataW        = 64;
  localparam int unsigned ProdW           = 2 * DataW;
  localparam int unsigned PairW           = ProdW + 1;
  localparam int unsigned SumW            = ProdW + 2;

  localparam logic signed [DataW-1:0] WordMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] WordMin = {1'b1, {(DataW-1){1'b0}}};

  // configuration register indexes
  typedef enum logic [RegIdxW-1:0] {
    REG_ROW0_COLS01 = 4'd0,
    REG_ROW0_COLS23 = 4'd1,
    REG_ROW1_COLS01 = 4'd2,
    REG_ROW1_COLS23 = 4'd3,
    REG_ROW2_COLS01 = 4'd4,
    REG_ROW2_COLS23 = 4'd5,
    REG_ROW3_COLS01 = 4'd6,
    REG_ROW3_COLS23 = 4'd7
  } mvt_reg_e;

  typedef struct packed {
    logic signed [DataW-1:0] in_x;
    logic signed [DataW-1:0] in_y;
    logic signed [DataW-1:0] in_z;
    logic signed [DataW-1:0] in_w;
  } mvt_vec_t;

  typedef struct packed {
    logic signed [DataW-1:0] out_x;
    logic signed [DataW-1:0] out_y;
    logic signed [DataW-1:0] out_z;
    logic signed [DataW-1:0] out_w;
    logic                    saturated;
  } mvt_res_t;

  typedef struct packed {
    logic [RegIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] wdata;
  } mvt_cfg_t;

  // [row][col]
  typedef logic [NumRows-1:0][NumCols-1:0][DataW-1:0] mvt_mat_t;
  typedef logic [NumRows-1:0][NumCols-1:0][ProdW-1:0] mvt_prod_t;
  typedef logic [NumRows-1:0][1:0][PairW-1:0]         mvt_pair_t;
  typedef logic [NumRows-1:0][SumW-1:0]               mvt_sum_t;

endpackage

/* hw/rtl/mvt_chan_if.sv */
interface mvt_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/mvt_cfg_regs.sv */
module mvt_cfg_regs #(
  parameter int unsigned FracBits = mvt_pkg::FracBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  mvt_chan_if.sink         cfg_i,
  output mvt_pkg::mvt_mat_t mat_o
);
  import mvt_pkg::*;

  localparam logic [DataW-1:0] OneFx = DataW'(1) << FracBits;

  mvt_mat_t mat_q;

  assign cfg_i.ready = 1'b1;
  assign mat_o       = mat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // identity: one on the diagonal, zero elsewhere
      for (int r = 0; r < NumRows; r++) begin
        for (int c = 0; c < NumCols; c++) begin
          mat_q[r][c] <= (r == c) ? OneFx : '0;
        end
      end
    end else if (cfg_i.valid) begin
      // even column in the low word, odd column in the high word
      case (mvt_reg_e'(cfg_i.data.reg_idx))
        REG_ROW0_COLS01: begin
          mat_q[0][0] <= cfg_i.data.wdata[DataW-1:0];
          mat_q[0][1] <= cfg_i.data.wdata[CfgDataW-1:DataW];
        end
        REG_ROW0_COLS23: begin
          mat_q[0][2] <= cfg_i.data.wdata[DataW-1:0];
          mat_q[0][3] <= cfg_i.data.wdata[CfgDataW-1:DataW];
        end
        REG_ROW1_COLS01: begin
          mat_q[1][0] <= cfg_i.data.wdata[DataW-1:0];
          mat_q[1][1] <= cfg_i.data.wdata[CfgDataW-1:DataW];
        end
        REG_ROW1_COLS23: begin
          mat_q[1][2] <= cfg_i.data.wdata[DataW-1:0];
          mat_q[1][3] <= cfg_i.data.wdata[CfgDataW-1:DataW];
        end
        REG_ROW2_COLS01: begin
          mat_q[2][0] <= cfg_i.data.wdata[DataW-1:0];
          mat_q[2][1] <= cfg_i.data.wdata[CfgDataW-1:DataW];
        end
        REG_ROW2_COLS23: begin
          mat_q[2][2] <= cfg_i.data.wdata[DataW-1:0];
          mat_q[2][3] <= cfg_i.data.wdata[CfgDataW-1:DataW];
        end
        REG_ROW3_COLS01: begin
          mat_q[3][0] <= cfg_i.data.wdata[DataW-1:0];
          mat_q[3][1] <= cfg_i.data.wdata[CfgDataW-1:DataW];
        end
        REG_ROW3_COLS23: begin
          mat_q[3][2] <= cfg_i.data.wdata[DataW-1:0];
          mat_q[3][3] <= cfg_i.data.wdata[CfgDataW-1:DataW];
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // out-of-range index must not touch the matrix
  a_bad_idx_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_i.valid && (cfg_i.data.reg_idx >= RegIdxW'(NumRegs))) |=> $stable(mat_q))
    else $error("write to unknown register changed the matrix");
`endif

endmodule

/* hw/rtl/mvt_mul_stage.sv */
module mvt_mul_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  mvt_chan_if.sink           vec_i,
  input  mvt_pkg::mvt_mat_t  mat_i,
  output logic               valid_o,
  input  logic               ready_i,
  output mvt_pkg::mvt_prod_t prod_o
);
  import mvt_pkg::*;

  logic      valid_q;
  mvt_prod_t prod_q;
  mvt_prod_t prod_d;
  logic signed [NumCols-1:0][DataW-1:0] comp;

  assign comp = {vec_i.data.in_x, vec_i.data.in_y, vec_i.data.in_z, vec_i.data.in_w};

  // sixteen 32x32 signed products, one per matrix entry
  always_comb begin
    for (int r = 0; r < NumRows; r++) begin
      for (int c = 0; c < NumCols; c++) begin
        prod_d[r][c] = ProdW'($signed(ProdW'($signed(mat_i[r][c])) *
                                      ProdW'($signed(comp[NumCols-1-c]))));
      end
    end
  end

  assign vec_i.ready = !valid_q || ready_i;
  assign valid_o     = valid_q;
  assign prod_o      = prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (vec_i.ready) begin
      valid_q <= vec_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vec_i.valid && vec_i.ready) begin
      prod_q <= prod_d;
    end
  end

`ifndef SYNTHESIS
  a_prod_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ready_i) |=> (valid_q && $stable(prod_q)))
    else $error("stalled product stage lost or changed its data");
`endif

endmodule

/* hw/rtl/mvt_sum_stage.sv */
module mvt_sum_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  mvt_pkg::mvt_prod_t prod_i,
  output logic               valid_o,
  input  logic               ready_i,
  output mvt_pkg::mvt_sum_t  sum_o
);
  import mvt_pkg::*;

  logic      pair_valid_q;
  logic      sum_valid_q;
  logic      pair_ready;
  mvt_pair_t pair_q;
  mvt_sum_t  sum_q;

  assign pair_ready = !sum_valid_q || ready_i;
  assign ready_o    = !pair_valid_q || pair_ready;
  assign valid_o    = sum_valid_q;
  assign sum_o      = sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_valid_q <= 1'b0;
      sum_valid_q  <= 1'b0;
    end else begin
      if (ready_o) begin
        pair_valid_q <= valid_i;
      end
      if (pair_ready) begin
        sum_valid_q <= pair_valid_q;
      end
    end
  end

  // first level: columns 0+1 and 2+3 of each row
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      for (int r = 0; r < NumRows; r++) begin
        pair_q[r][0] <= PairW'($signed(prod_i[r][0])) + PairW'($signed(prod_i[r][1]));
        pair_q[r][1] <= PairW'($signed(prod_i[r][2])) + PairW'($signed(prod_i[r][3]));
      end
    end
  end

  // second level: exact row total
  always_ff @(posedge clk_i) begin
    if (pair_valid_q && pair_ready) begin
      for (int r = 0; r < NumRows; r++) begin
        sum_q[r] <= SumW'($signed(pair_q[r][0])) + SumW'($signed(pair_q[r][1]));
      end
    end
  end

endmodule

/* hw/rtl/mvt_sat_stage.sv */
module mvt_sat_stage #(
  parameter int unsigned FracBits = mvt_pkg::FracBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  mvt_pkg::mvt_sum_t sum_i,
  mvt_chan_if.source        res_o
);
  import mvt_pkg::*;

  logic     valid_q;
  mvt_res_t res_q;
  mvt_res_t res_d;
  logic signed [NumRows-1:0][DataW-1:0] word;
  logic [NumRows-1:0] clamp;

  always_comb begin
    logic signed [SumW-1:0] shifted;
    for (int r = 0; r < NumRows; r++) begin
      // arithmetic shift floors toward minus infinity
      shifted = $signed(sum_i[r]) >>> FracBits;
      clamp[r] = !((&shifted[SumW-1:DataW-1]) || !(|shifted[SumW-1:DataW-1]));
      if (!clamp[r]) begin
        word[r] = shifted[DataW-1:0];
      end else if (shifted[SumW-1]) begin
        word[r] = WordMin;
      end else begin
        word[r] = WordMax;
      end
    end
    res_d.out_x     = word[0];
    res_d.out_y     = word[1];
    res_d.out_z     = word[2];
    res_d.out_w     = word[3];
    res_d.saturated = |clamp;
  end

  assign ready_o     = !valid_q || res_o.ready;
  assign res_o.valid = valid_q;
  assign res_o.data  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_d;
    end
  end

`ifndef SYNTHESIS
  a_sat_flag_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && res_q.saturated) |->
      ((res_q.out_x == WordMax) || (res_q.out_x == WordMin) ||
       (res_q.out_y == WordMax) || (res_q.out_y == WordMin) ||
       (res_q.out_z == WordMax) || (res_q.out_z == WordMin) ||
       (res_q.out_w == WordMax) || (res_q.out_w == WordMin)))
    else $error("saturated flag set with no clamped component");
`endif

endmodule

/* hw/rtl/matrix_vector_transform.sv */
// Homogeneous 4x4 matrix-vector transform in signed fixed point (FracBits fraction
// bits, 32-bit words). Each vector request on vec_i gives one result request on res_o:
// each component is the exact sum of the four row-entry by component products,
// shifted right by FracBits with floor rounding and saturated to 32 bits; saturated
// flags any clamped component. The matrix lives in eight 64-bit registers written
// through cfg_i (index 0..7, row-major pairs, even column in bits 31:0, odd column in
// bits 63:32); it resets to identity, unknown indexes are ignored, and cfg_i is
// always ready. Write configuration only while no vector is in flight. The datapath
// is a four-stage pipeline: 16 parallel 32x32 multipliers, a pair-add level, a
// row-total level, and a shift/saturate output register. One vector is accepted
// every cycle unless the pipeline is stalled; the result is held in the output
// register until res_o takes it. Every stage has its own valid bit and advances
// when empty or when the stage after it moves, so bubbles are squeezed out and
// vec_i drops ready only when all four stages hold data and res_o is stalled.
module matrix_vector_transform #(
  parameter int unsigned FracBits = mvt_pkg::FracBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mvt_chan_if.sink   vec_i,
  mvt_chan_if.source res_o,
  mvt_chan_if.sink   cfg_i
);
  import mvt_pkg::*;

  // matrix from the register block
  mvt_mat_t  mat;

  // product stage to adder tree
  logic      prod_valid;
  logic      prod_ready;
  mvt_prod_t prod;

  // adder tree to saturation stage
  logic      sum_valid;
  logic      sum_ready;
  mvt_sum_t  sum;

  mvt_cfg_regs #(
    .FracBits (FracBits)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .mat_o  (mat)
  );

  // stage 1: all sixteen products at once
  mvt_mul_stage u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vec_i   (vec_i),
    .mat_i   (mat),
    .valid_o (prod_valid),
    .ready_i (prod_ready),
    .prod_o  (prod)
  );

  // stages 2 and 3: two-level adder tree per row, full precision
  mvt_sum_stage u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .ready_o (prod_ready),
    .prod_i  (prod),
    .valid_o (sum_valid),
    .ready_i (sum_ready),
    .sum_o   (sum)
  );

  // stage 4: floor shift, clamp and output register
  mvt_sat_stage #(
    .FracBits (FracBits)
  ) u_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_valid),
    .ready_o (sum_ready),
    .sum_i   (sum),
    .res_o   (res_o)
  );

`ifndef SYNTHESIS
  // back-pressure reaches the input only through a full, stalled pipeline
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vec_i.ready |-> (res_o.valid && !res_o.ready && prod_valid && sum_valid))
    else $error("input stalled while the pipeline could move");
`endif

endmodule
